[src/neighbor_color_edge_weight_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the neighbor color edge weight block
// Clocked, reset-qualified implication checks reporting through $error.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_COLOR_EDGE_WEIGHT_TOP_ASSERT_SVH
`define NEIGHBOR_COLOR_EDGE_WEIGHT_TOP_ASSERT_SVH

// same-cycle implication
`define NCEW_ASSERT_IMPLY(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define NCEW_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[src/ncew_pkg.sv]
// ---------------------------------------------------------------------------
// ncew_pkg
// Types, register codes, widths and the exponential weight table of the
// neighbor color edge weight block.
// ---------------------------------------------------------------------------
package ncew_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT         = 4096;
   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   localparam int COLOR_W  = 8;
   localparam int CFG_W    = 13;
   localparam int ROW_W    = 12;
   localparam int NODE_W   = 24;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 18;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam int LANES     = 2;
   localparam int LANE_UP   = 0;
   localparam int LANE_LEFT = 1;

   localparam int ROOT_BITS   = 12;
   localparam int RAD_W       = 2 * ROOT_BITS;
   localparam int REM_W       = ROOT_BITS + 2;
   localparam int ROOT_STEPS  = 6;
   localparam int ROOT_CYCLES = ROOT_BITS / ROOT_STEPS;

   localparam int DECAY_SCALE  = 30;
   localparam int DIST_ENTRIES = 1767;
   localparam int DIST_AW      = $clog2(DIST_ENTRIES);
   localparam int FRAC_BITS    = 60;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic                frame_done;
   } edge_type;

   typedef struct packed {
      logic [RAD_W-1:0]     rad;
      logic [REM_W-1:0]     rem;
      logic [ROOT_BITS-1:0] root;
   } root_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INDEX,
      ST_ROOT,
      ST_LOOKUP,
      ST_UP_FWD,
      ST_UP_BACK,
      ST_LEFT_FWD,
      ST_LEFT_BACK
   } state_type;

   // exp(-1 / (4 * DECAY_SCALE)) in Q4.60 from its series
   localparam logic [63:0] EXP_ONE = 64'd1 << FRAC_BITS;
   localparam logic [63:0] EXP_DIV = 64'(4 * DECAY_SCALE);
   localparam logic [63:0] EXP_T1  = EXP_ONE / EXP_DIV;
   localparam logic [63:0] EXP_T2  = EXP_T1 / (EXP_DIV * 64'd2);
   localparam logic [63:0] EXP_T3  = EXP_T2 / (EXP_DIV * 64'd3);
   localparam logic [63:0] EXP_T4  = EXP_T3 / (EXP_DIV * 64'd4);
   localparam logic [63:0] EXP_T5  = EXP_T4 / (EXP_DIV * 64'd5);
   localparam logic [63:0] EXP_T6  = EXP_T5 / (EXP_DIV * 64'd6);
   localparam logic [63:0] EXP_T7  = EXP_T6 / (EXP_DIV * 64'd7);
   localparam logic [63:0] EXP_T8  = EXP_T7 / (EXP_DIV * 64'd8);
   localparam logic [63:0] EXP_T9  = EXP_T8 / (EXP_DIV * 64'd9);
   localparam logic [63:0] EXP_T10 = EXP_T9 / (EXP_DIV * 64'd10);
   localparam logic [63:0] EXP_T11 = EXP_T10 / (EXP_DIV * 64'd11);
   localparam logic [63:0] EXP_T12 = EXP_T11 / (EXP_DIV * 64'd12);
   localparam logic [63:0] EXP_T13 = EXP_T12 / (EXP_DIV * 64'd13);
   localparam logic [63:0] EXP_T14 = EXP_T13 / (EXP_DIV * 64'd14);
   localparam logic [63:0] EXP_T15 = EXP_T14 / (EXP_DIV * 64'd15);
   localparam logic [63:0] EXP_T16 = EXP_T15 / (EXP_DIV * 64'd16);
   localparam logic [63:0] EXP_RATIO = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                     - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                     + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                     + EXP_T14 - EXP_T15 + EXP_T16;

   function automatic logic [DIST_ENTRIES*WEIGHT_W-1:0] build_weight_rom();
      logic [DIST_ENTRIES*WEIGHT_W-1:0] rom_bits;
      logic [63:0]                      p;
      logic [63:0]                      w;
      logic [127:0]                     prod;
      p = EXP_ONE;
      rom_bits = '0;
      for (int i = 0; i < DIST_ENTRIES; i++) begin
         w = (p + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
         rom_bits[i*WEIGHT_W +: WEIGHT_W] = (w > 64'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
         prod = {64'd0, p} * {64'd0, EXP_RATIO};
         p = prod[FRAC_BITS +: 64];
      end
      return rom_bits;
   endfunction

   localparam logic [DIST_ENTRIES*WEIGHT_W-1:0] WEIGHT_ROM = build_weight_rom();

endpackage

[src/neighbor_color_edge_weight_top.sv]
// ---------------------------------------------------------------------------
// neighbor_color_edge_weight_top
// Raster-order RGB pixels in, symmetric 4-neighbor edge potentials out.
// ---------------------------------------------------------------------------
//  channel   direction  transfer                     payload
//  req_      in         req_valid & req_ready        pixel_type (red, green, blue)
//  rsp_      out        rsp_valid & rsp_ready        edge_type (nodes, weight, marks)
//  csr_      in         csr_we                       image_width / image_height
//
//  A pixel with no results is only accepted; one with two or four results goes
//  through accept, index multiply, the 6-bit-per-cycle square root, the weight
//  table read, then one result at a time through the output register.
//  Output stalls hold only the result states; the next pixel is taken
//  while the last result still waits. Reset is synchronous; the line buffer
//  has no clearing pass.
// ---------------------------------------------------------------------------
`include "neighbor_color_edge_weight_top_assert.svh"

module neighbor_color_edge_weight_top
   import ncew_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pixel_type              req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output edge_type               rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int RCW = (ROOT_CYCLES > 1) ? $clog2(ROOT_CYCLES) : 1;
   localparam int PIX_W = $bits(pixel_type);
   localparam logic [WW-1:0] WIDTH_RESET =
      WW'((IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(IMAGE_HEIGHT_RESET);

   function automatic logic [RAD_W-1:0] radicand(pixel_type a, pixel_type b);
      logic [COLOR_W-1:0]   dr;
      logic [COLOR_W-1:0]   dg;
      logic [COLOR_W-1:0]   db;
      logic [2*COLOR_W-1:0] sr;
      logic [2*COLOR_W-1:0] sg;
      logic [2*COLOR_W-1:0] sb;
      logic [SUM_W-1:0]     s2;
      dr = (a.red >= b.red) ? a.red - b.red : b.red - a.red;
      dg = (a.green >= b.green) ? a.green - b.green : b.green - a.green;
      db = (a.blue >= b.blue) ? a.blue - b.blue : b.blue - a.blue;
      sr = dr * dr;
      sg = dg * dg;
      sb = db * db;
      s2 = SUM_W'(sr) + SUM_W'(sg) + SUM_W'(sb);
      return RAD_W'({s2, 4'b0000});
   endfunction

   function automatic root_type root_advance(root_type cur);
      root_type           nxt;
      logic [REM_W+1:0]   acc;
      logic [REM_W+1:0]   trial;
      nxt = cur;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         acc   = {nxt.rem, nxt.rad[RAD_W-1 -: 2]};
         trial = (REM_W + 2)'({nxt.root, 2'b01});
         if (acc >= trial) begin
            nxt.rem  = REM_W'(acc - trial);
            nxt.root = {nxt.root[ROOT_BITS-2:0], 1'b1};
         end else begin
            nxt.rem  = REM_W'(acc);
            nxt.root = {nxt.root[ROOT_BITS-2:0], 1'b0};
         end
         nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
      end
      return nxt;
   endfunction

   state_type state_ff, state_in;

   logic [WW-1:0]    width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CW-1:0]    col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;

   logic [CW-1:0]    col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             has_up_ff, has_left_ff, final_ff;
   pixel_type        pix_ff, left_pixel_ff, left_old_ff;
   logic [PIX_W-1:0] mem_rd_ff;
   logic [PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [NODE_W-1:0] idx_ff, idx_in;
   logic [ROW_W+WW-1:0] idx_prod;

   root_type          root_ff [LANES];
   root_type          root_in [LANES];
   logic [RCW-1:0]    root_cnt_ff;
   logic [DIST_AW-1:0] rom_addr [LANES];
   logic [WEIGHT_W-1:0] weight_ff [LANES];

   logic             rsp_valid_ff;
   edge_type         rsp_data_ff, rsp_data_in;
   logic             rsp_load;

   logic             accept;
   logic             col_wrap;
   logic [CW-1:0]    cur_col;
   logic [CFG_W-1:0] row_tmp;
   logic [ROW_W-1:0] cur_row;
   logic [WW-1:0]    col_next;
   logic             end_row;
   logic [CFG_W-1:0] row_next;
   logic             has_up_new, has_left_new, final_new;
   logic [NODE_W-1:0] up_idx, left_idx;
   logic             slot_free;

   // position of the incoming pixel and the counters after it
   always_comb begin
      col_wrap   = WW'(col_cnt_ff) >= width_ff;
      cur_col    = col_wrap ? '0 : col_cnt_ff;
      row_tmp    = CFG_W'(row_cnt_ff) + CFG_W'(col_wrap);
      cur_row    = (row_tmp >= height_ff) ? '0 : row_tmp[ROW_W-1:0];
      col_next   = WW'(cur_col) + WW'(1);
      end_row    = col_next >= width_ff;
      row_next   = CFG_W'(cur_row) + CFG_W'(1);
      col_cnt_in = end_row ? '0 : col_next[CW-1:0];
      if (end_row) begin
         row_cnt_in = (row_next >= height_ff) ? '0 : row_next[ROW_W-1:0];
      end else begin
         row_cnt_in = cur_row;
      end
      has_up_new   = cur_row != '0;
      has_left_new = cur_col != '0;
      final_new    = (CFG_W'(cur_row) == height_ff - CFG_W'(1)) &&
                     (WW'(cur_col) == width_ff - WW'(1));
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_ff <= WW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  width_ff <= WW'(MAX_WIDTH);
               end else begin
                  width_ff <= WW'(csr_wdata);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_ff <= CFG_W'(1);
               end else if (csr_wdata > CFG_W'(MAX_HEIGHT)) begin
                  height_ff <= CFG_W'(MAX_HEIGHT);
               end else begin
                  height_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         has_up_ff   <= 1'b0;
         has_left_ff <= 1'b0;
         final_ff    <= 1'b0;
      end else if (accept) begin
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         has_up_ff   <= has_up_new;
         has_left_ff <= has_left_new;
         final_ff    <= final_new;
      end
   end

   // line buffer: read the pixel above, write the current pixel in its place
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff         <= line_mem[cur_col];
         line_mem[cur_col] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff        <= req_data;
         left_old_ff   <= left_pixel_ff;
         left_pixel_ff <= req_data;
         col_ff        <= cur_col;
         row_ff        <= cur_row;
      end
   end

   assign idx_prod = row_ff * width_ff;
   assign idx_in   = NODE_W'(idx_prod) + NODE_W'(col_ff);
   assign up_idx   = idx_ff - NODE_W'(width_ff);
   assign left_idx = idx_ff - NODE_W'(1);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (state_ff == ST_INDEX) begin
            root_in[l].rem  = '0;
            root_in[l].root = '0;
            if (l == LANE_UP) begin
               root_in[l].rad = radicand(pix_ff, pixel_type'(mem_rd_ff));
            end else begin
               root_in[l].rad = radicand(pix_ff, left_old_ff);
            end
         end else begin
            root_in[l] = root_advance(root_ff[l]);
         end
         rom_addr[l] = (root_ff[l].root >= ROOT_BITS'(DIST_ENTRIES)) ?
                       DIST_AW'(DIST_ENTRIES - 1) : root_ff[l].root[DIST_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INDEX) begin
         idx_ff <= idx_in;
      end
      if (state_ff == ST_INDEX || state_ff == ST_ROOT) begin
         for (int l = 0; l < LANES; l++) begin
            root_ff[l] <= root_in[l];
         end
      end
      if (state_ff == ST_LOOKUP) begin
         for (int l = 0; l < LANES; l++) begin
            weight_ff[l] <= WEIGHT_ROM[{rom_addr[l], 4'b0000} +: WEIGHT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_cnt_ff <= '0;
      end else if (state_ff == ST_INDEX) begin
         root_cnt_ff <= '0;
      end else if (state_ff == ST_ROOT) begin
         root_cnt_ff <= root_cnt_ff + RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = '{from_node: idx_ff, to_node: up_idx, weight: weight_ff[LANE_UP],
                      last: 1'b0, frame_done: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (has_up_new || has_left_new)) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_cnt_ff == RCW'(ROOT_CYCLES - 1)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = has_up_ff ? ST_UP_FWD : ST_LEFT_FWD;
         end
         ST_UP_FWD: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_UP_BACK;
            end
         end
         ST_UP_BACK: begin
            rsp_data_in.from_node  = up_idx;
            rsp_data_in.to_node    = idx_ff;
            rsp_data_in.last       = !has_left_ff;
            rsp_data_in.frame_done = !has_left_ff && final_ff;
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = has_left_ff ? ST_LEFT_FWD : ST_IDLE;
            end
         end
         ST_LEFT_FWD: begin
            rsp_data_in.to_node = left_idx;
            rsp_data_in.weight  = weight_ff[LANE_LEFT];
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_LEFT_BACK;
            end
         end
         ST_LEFT_BACK: begin
            rsp_data_in.from_node  = left_idx;
            rsp_data_in.to_node    = idx_ff;
            rsp_data_in.weight     = weight_ff[LANE_LEFT];
            rsp_data_in.last       = 1'b1;
            rsp_data_in.frame_done = final_ff;
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold while stalled, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NCEW_ASSERT_IMPLY(a_root_range, clock, reset, state_ff == ST_LOOKUP, (!has_up_ff || root_ff[LANE_UP].root < ROOT_BITS'(DIST_ENTRIES)) && (!has_left_ff || root_ff[LANE_LEFT].root < ROOT_BITS'(DIST_ENTRIES)), "square root beyond weight table")
   `NCEW_ASSERT_IMPLY(a_distinct_nodes, clock, reset, rsp_valid, rsp_data.from_node != rsp_data.to_node, "edge joins a node to itself")
   `NCEW_ASSERT_NEXT(a_last_ends_pixel, clock, reset, rsp_load && rsp_data_in.last, state_ff == ST_IDLE, "sequencer busy after final transaction of a pixel")

endmodule
